// File: sv/sdt_pkg.sv
// Package with the types, constants and codes of the scanned device table.
`default_nettype none

package sdt_pkg;

  localparam int unsigned TableDepth = 16;
  localparam int unsigned IdxW       = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CountW     = $clog2(TableDepth + 1);

  localparam int unsigned AddrW      = 48;
  localparam int unsigned RssiW      = 8;
  localparam int unsigned EntryIdxW  = 4;
  localparam int unsigned TotalW     = 5;

  localparam int unsigned PaddrW     = 3;
  localparam int unsigned PdataW     = 32;
  localparam int unsigned ThreshW    = 8;
  localparam logic [ThreshW-1:0] ThreshReset = 8'd5;

  typedef enum logic [0:0] {
    RegRssiThreshold = 1'b0
  } reg_idx_e;

  typedef enum logic [1:0] {
    StatusNew       = 2'd0,
    StatusUpdated   = 2'd1,
    StatusUnchanged = 2'd2,
    StatusDropped   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    StIdle   = 2'd0,
    StScan   = 2'd1,
    StUpdate = 2'd2
  } state_e;

  typedef struct packed {
    logic [AddrW-1:0]        device_address;
    logic signed [RssiW-1:0] signal_strength;
    logic                    name_present;
  } report_t;

  typedef struct packed {
    logic [EntryIdxW-1:0]    entry_index;
    status_e                 status;
    logic                    rssi_updated;
    logic                    name_gained;
    logic                    refresh_needed;
    logic signed [RssiW-1:0] stored_rssi;
    logic [TotalW-1:0]       device_total;
  } result_t;

endpackage

`default_nettype wire

// File: sv/scanned_device_table.sv
// Scanned device table: address lookup, append (drop when full) and RSSI/name update.
// A report is accepted while busy is low; the table is then scanned slot by
// slot until the address matches or the stored entries run out, the entry is
// updated or appended, and the result strobes done_o. The next report is taken
// at the end of the strobe cycle, not before; one comparator scans the table.
// Reset clears the entry count and restores the RSSI threshold to 5.
`default_nettype none

module scanned_device_table (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output      logic                         busy,
  input  wire sdt_pkg::report_t             report_i,
  output      logic                         done_o,
  output      sdt_pkg::result_t             result_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [sdt_pkg::PaddrW-1:0]   paddr,
  input  wire logic [sdt_pkg::PdataW-1:0]   pwdata,
  output      logic [sdt_pkg::PdataW-1:0]   prdata,
  output      logic                         pready
);

  logic [sdt_pkg::AddrW-1:0]        addr_mem  [sdt_pkg::TableDepth];
  logic [sdt_pkg::RssiW-1:0]        rssi_mem  [sdt_pkg::TableDepth];
  logic                             named_mem [sdt_pkg::TableDepth];

  sdt_pkg::state_e                  state_q, state_d;
  logic [sdt_pkg::ThreshW-1:0]      thresh_q;
  logic [sdt_pkg::CountW-1:0]       count_q;
  logic [sdt_pkg::CountW-1:0]       issue_cnt_q;
  logic                             cmp_valid_q;
  logic [sdt_pkg::IdxW-1:0]         cmp_idx_q;
  logic [sdt_pkg::IdxW-1:0]         slot_q;
  logic                             found_q;
  sdt_pkg::report_t                 report_q;
  logic [sdt_pkg::AddrW-1:0]        rd_addr_q;
  logic [sdt_pkg::RssiW-1:0]        rd_rssi_q;
  logic                             rd_named_q;
  logic                             done_q;
  sdt_pkg::result_t                 result_q, result_d;

  logic                             accept;
  logic                             issue_en;
  logic                             hit;
  logic                             scan_end;
  logic                             full;
  logic                             cfg_wr;
  logic signed [sdt_pkg::RssiW:0]   diff;
  logic [sdt_pkg::RssiW:0]          mag;
  logic                             rssi_upd;
  logic                             name_gain;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite
                  && (paddr[sdt_pkg::PaddrW-1] == sdt_pkg::RegRssiThreshold);
  assign prdata = (paddr[sdt_pkg::PaddrW-1] == sdt_pkg::RegRssiThreshold)
                  ? {{(sdt_pkg::PdataW - sdt_pkg::ThreshW){1'b0}}, thresh_q}
                  : '0;

  assign full = (count_q == sdt_pkg::CountW'(sdt_pkg::TableDepth));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      sdt_pkg::StIdle: begin
        if (start) begin
          state_d = sdt_pkg::StScan;
        end
      end
      sdt_pkg::StScan: begin
        if (hit || scan_end) begin
          state_d = sdt_pkg::StUpdate;
        end
      end
      sdt_pkg::StUpdate: begin
        state_d = sdt_pkg::StIdle;
      end
      default: begin
        state_d = sdt_pkg::StIdle;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    busy     = 1'b1;
    accept   = 1'b0;
    hit      = 1'b0;
    issue_en = 1'b0;
    scan_end = 1'b0;
    case (state_q)
      sdt_pkg::StIdle: begin
        busy   = 1'b0;
        accept = start;
      end
      sdt_pkg::StScan: begin
        hit      = cmp_valid_q && (rd_addr_q == report_q.device_address);
        issue_en = !hit && (issue_cnt_q < count_q);
        scan_end = !hit && !cmp_valid_q && (issue_cnt_q >= count_q);
      end
      sdt_pkg::StUpdate: begin
      end
      default: begin
      end
    endcase
  end

  assign diff = $signed({rd_rssi_q[sdt_pkg::RssiW-1], rd_rssi_q})
                - $signed({report_q.signal_strength[sdt_pkg::RssiW-1],
                           report_q.signal_strength});
  assign mag       = diff[sdt_pkg::RssiW] ? $unsigned(-diff) : $unsigned(diff);
  assign rssi_upd  = (mag >= {1'b0, thresh_q});
  assign name_gain = !rd_named_q && report_q.name_present;

  always_comb begin
    result_d = '0;
    if (found_q) begin
      result_d.entry_index    = sdt_pkg::EntryIdxW'(slot_q);
      result_d.status         = (rssi_upd || name_gain) ? sdt_pkg::StatusUpdated
                                                        : sdt_pkg::StatusUnchanged;
      result_d.rssi_updated   = rssi_upd;
      result_d.name_gained    = name_gain;
      result_d.refresh_needed = rssi_upd || name_gain;
      result_d.stored_rssi    = rssi_upd ? report_q.signal_strength
                                         : $signed(rd_rssi_q);
      result_d.device_total   = sdt_pkg::TotalW'(count_q);
    end else if (!full) begin
      result_d.entry_index    = sdt_pkg::EntryIdxW'(count_q);
      result_d.status         = sdt_pkg::StatusNew;
      result_d.rssi_updated   = 1'b1;
      result_d.name_gained    = report_q.name_present;
      result_d.refresh_needed = 1'b1;
      result_d.stored_rssi    = report_q.signal_strength;
      result_d.device_total   = sdt_pkg::TotalW'(count_q + 1'b1);
    end else begin
      result_d.status         = sdt_pkg::StatusDropped;
      result_d.device_total   = sdt_pkg::TotalW'(count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sdt_pkg::StIdle;
      thresh_q    <= sdt_pkg::ThreshReset;
      count_q     <= '0;
      issue_cnt_q <= '0;
      cmp_valid_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == sdt_pkg::StUpdate);
      if (cfg_wr) begin
        thresh_q <= pwdata[sdt_pkg::ThreshW-1:0];
      end
      if (accept) begin
        issue_cnt_q <= '0;
        cmp_valid_q <= 1'b0;
      end else if (state_q == sdt_pkg::StScan) begin
        cmp_valid_q <= issue_en;
        if (issue_en) begin
          issue_cnt_q <= issue_cnt_q + 1'b1;
        end
      end
      if ((state_q == sdt_pkg::StUpdate) && !found_q && !full) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      report_q <= report_i;
    end
    if (issue_en) begin
      cmp_idx_q <= issue_cnt_q[sdt_pkg::IdxW-1:0];
    end
    if (state_q == sdt_pkg::StScan) begin
      found_q <= hit;
      slot_q  <= cmp_idx_q;
    end
    if (state_q == sdt_pkg::StUpdate) begin
      result_q <= result_d;
    end
  end

  // Table memories: one registered read port, one write port.
  always_ff @(posedge clk_i) begin
    if (issue_en) begin
      rd_addr_q  <= addr_mem[issue_cnt_q[sdt_pkg::IdxW-1:0]];
      rd_rssi_q  <= rssi_mem[issue_cnt_q[sdt_pkg::IdxW-1:0]];
      rd_named_q <= named_mem[issue_cnt_q[sdt_pkg::IdxW-1:0]];
    end
    if (state_q == sdt_pkg::StUpdate) begin
      if (found_q) begin
        if (rssi_upd) begin
          rssi_mem[slot_q] <= report_q.signal_strength;
        end
        if (name_gain) begin
          named_mem[slot_q] <= 1'b1;
        end
      end else if (!full) begin
        addr_mem[count_q[sdt_pkg::IdxW-1:0]]  <= report_q.device_address;
        rssi_mem[count_q[sdt_pkg::IdxW-1:0]]  <= report_q.signal_strength;
        named_mem[count_q[sdt_pkg::IdxW-1:0]] <= report_q.name_present;
      end
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

`default_nettype wire
